// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, quiet during rst.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked on clk, quiet during rst.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/cfsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfsa_pkg;

  localparam int NUM_LANES = 32;
  localparam int MULT_BITS = 16;

  localparam int LANE_W  = 5;
  localparam int VEXP_W  = 6;
  localparam int VMANT_W = 15;
  localparam int MULT_W  = 16;
  localparam int EXP_W   = 7;
  localparam int MANT_W  = 16;

  localparam int LANE_IDX_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int STEP_W     = (MULT_BITS > 1) ? $clog2(MULT_BITS) : 1;

  localparam logic [EXP_W-1:0]   EXP_MAX     = EXP_W'(63);
  localparam logic [VEXP_W-1:0]  OUT_EXP_MAX = VEXP_W'(63);
  localparam logic [MANT_W-1:0]  MANT_LIMIT  = MANT_W'(16'h7FFF);
  localparam logic [VMANT_W-1:0] OUT_MANT_MAX = VMANT_W'(15'h7FFF);
  localparam logic [EXP_W-1:0]   SHIFT_LIM   = EXP_W'(MANT_W);

  localparam logic ACT_ACC   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic [EXP_W-1:0]  expo;
    logic [MANT_W-1:0] mant;
  } lane_sum_t;

endpackage

`default_nettype wire

// ===== hw/rtl/custom_float_scale_accumulate.sv =====
// Per-lane running sums in a custom unsigned float (7-bit exponent, bias 31, 16-bit mantissa
// with 2^0 at bit 14), held in one synchronous memory with valid bits that reset clears at
// once, so no clearing pass follows reset. An accumulate beat scales its value by the
// multiplier with one truncating float adder that walks the multiplier one bit per cycle,
// then adds the product to the lane sum read from memory and writes it back. A clear beat,
// or a beat for a lane beyond the lane count, skips the bit walk and goes straight to the
// result step. One item is in flight at a time; the next beat is taken while the previous
// result still waits on the output register.
// Sums whose exponent passes 63 saturate to exponent 63, mantissa 0x7FFF, and raise overflow.
`timescale 1ns / 1ps
`default_nettype none

module custom_float_scale_accumulate
  import cfsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 action,
  input  logic [LANE_W-1:0]    lane,
  input  logic [VEXP_W-1:0]    value_exponent,
  input  logic [VMANT_W-1:0]   value_mantissa,
  input  logic [MULT_W-1:0]    multiplier,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [LANE_W-1:0]    out_lane,
  output logic [VEXP_W-1:0]    sum_exp_out,
  output logic [VMANT_W-1:0]   sum_mant_out,
  output logic                 overflow
);

  typedef enum logic [1:0] {IDLE, STEP, DONE} state_t;

  function automatic lane_sum_t tadd(lane_sum_t a, lane_sum_t b);
    logic [EXP_W-1:0]  d;
    logic [MANT_W-1:0] am;
    logic [MANT_W-1:0] bm;
    logic [MANT_W-1:0] s;
    lane_sum_t         r;
    r  = a;
    am = a.mant;
    bm = b.mant;
    d  = '0;
    s  = '0;
    if (a.expo == '0 && a.mant == '0) begin
      r = b;
    end else if (b.expo == '0 && b.mant == '0) begin
      r = a;
    end else begin
      if (a.expo > b.expo) begin
        d      = a.expo - b.expo;
        bm     = (d >= SHIFT_LIM) ? '0 : (bm >> d);
        r.expo = a.expo;
      end else if (b.expo > a.expo) begin
        d      = b.expo - a.expo;
        am     = (d >= SHIFT_LIM) ? '0 : (am >> d);
        r.expo = b.expo;
      end else begin
        r.expo = a.expo;
      end
      s = am + bm;
      if (s > MANT_LIMIT) begin
        r.expo = r.expo + 1'b1;
        s      = s >> 1;
      end
      r.mant = s;
    end
    return r;
  endfunction

  state_t                  state;
  logic                    act;
  logic                    hit;
  logic [LANE_W-1:0]       cur_lane;
  logic [LANE_IDX_W-1:0]   cur_idx;
  logic [VEXP_W-1:0]       vexp;
  logic [VMANT_W-1:0]      vmant;
  logic [MULT_BITS-1:0]    mult;
  logic [STEP_W-1:0]       step;
  lane_sum_t               prod;
  lane_sum_t               rd_word;
  logic                    rd_ok;
  logic [NUM_LANES-1:0]    lane_vld;
  lane_sum_t               mem [NUM_LANES];

  logic                    accept;
  logic [LANE_IDX_W-1:0]   in_idx;
  logic                    in_hit;
  logic                    out_free;
  logic                    mem_we;
  lane_sum_t               step_term;
  lane_sum_t               step_sum;
  lane_sum_t               base;
  lane_sum_t               fin;
  lane_sum_t               sat;
  logic                    sat_ovf;

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_idx     = LANE_IDX_W'(lane);
  assign in_hit     = (32'(lane) < 32'(NUM_LANES));
  assign out_free   = !result_valid || !result_stall;
  assign mem_we     = (state == DONE) && out_free && hit && (act == ACT_ACC);

  always_comb begin
    step_term.expo = EXP_W'(vexp) + EXP_W'(step);
    step_term.mant = MANT_W'(vmant);
    step_sum       = tadd(prod, step_term);
    base           = rd_ok ? rd_word : '0;
    fin            = tadd(base, prod);
    sat            = fin;
    sat_ovf        = 1'b0;
    if (fin.expo > EXP_MAX) begin
      sat.expo = EXP_MAX;
      sat.mant = MANT_LIMIT;
      sat_ovf  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= mem[in_idx];
    end
    if (mem_we) begin
      mem[cur_idx] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
      lane_vld     <= '0;
    end else begin
      if (state == DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            act      <= action;
            hit      <= in_hit;
            cur_lane <= lane;
            cur_idx  <= in_idx;
            vexp     <= value_exponent;
            vmant    <= value_mantissa;
            rd_ok    <= lane_vld[in_idx];
            step     <= '0;
            prod     <= '0;
            if (value_exponent == '0 && value_mantissa == '0) begin
              mult <= '0;
            end else begin
              mult <= MULT_BITS'(multiplier);
            end
            state <= (in_hit && action == ACT_ACC) ? STEP : DONE;
          end
        end
        STEP: begin
          if (mult[step]) begin
            prod <= step_sum;
          end
          step <= step + 1'b1;
          if (step == STEP_W'(MULT_BITS - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            out_lane     <= cur_lane;
            if (hit && act == ACT_ACC) begin
              sum_exp_out    <= VEXP_W'(sat.expo);
              sum_mant_out   <= VMANT_W'(sat.mant);
              overflow       <= sat_ovf;
              lane_vld[cur_idx] <= 1'b1;
            end else begin
              sum_exp_out  <= '0;
              sum_mant_out <= '0;
              overflow     <= 1'b0;
              if (hit) begin
                lane_vld[cur_idx] <= 1'b0;
              end
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfsa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cfsa_checker
  import cfsa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input logic [LANE_W-1:0]   out_lane,
  input logic [VEXP_W-1:0]   sum_exp_out,
  input logic [VMANT_W-1:0]  sum_mant_out,
  input logic                overflow
);

  `CHK_SAME(a_ovf_saturates, result_valid && overflow,
            sum_exp_out == OUT_EXP_MAX && sum_mant_out == OUT_MANT_MAX)
  `CHK_NEXT(a_busy_after_beat, item_valid && !item_stall, item_stall)
  `CHK_SAME(a_result_from_busy, $rose(result_valid), $past(item_stall))
  `CHK_NEXT(a_result_holds, result_valid && result_stall,
            result_valid && $stable(out_lane) && $stable(sum_exp_out))

endmodule

bind custom_float_scale_accumulate cfsa_checker u_cfsa_checker (.*);

`default_nettype wire

// ===== verif/custom_float_scale_accumulate_test.sv =====
`timescale 1ns / 1ps

module custom_float_scale_accumulate_test;
  import cfsa_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 850;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_AT     = 520;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 40;

  typedef struct {
    logic               action;
    logic [LANE_W-1:0]  lane;
    logic [VEXP_W-1:0]  vexp;
    logic [VMANT_W-1:0] vmant;
    logic [MULT_W-1:0]  mult;
    bit                 drain;
  } acc_beat_t;

  typedef struct {
    logic [LANE_W-1:0]  lane;
    logic [VEXP_W-1:0]  expo;
    logic [VMANT_W-1:0] mant;
    logic               ovf;
  } sum_beat_t;

  typedef struct {
    int unsigned e;
    int unsigned m;
  } cfloat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               action = ACT_ACC;
  logic [LANE_W-1:0]  lane = '0;
  logic [VEXP_W-1:0]  value_exponent = '0;
  logic [VMANT_W-1:0] value_mantissa = '0;
  logic [MULT_W-1:0]  multiplier = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [LANE_W-1:0]  out_lane;
  logic [VEXP_W-1:0]  sum_exp_out;
  logic [VMANT_W-1:0] sum_mant_out;
  logic               overflow;

  acc_beat_t   beats_to_send[$];
  acc_beat_t   offered;
  sum_beat_t   sums_due[$];
  int unsigned lane_exp[NUM_LANES];
  int unsigned lane_mant[NUM_LANES];
  int          items_in = 0;
  int          results_out = 0;
  int          errors = 0;
  int          send_gap = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;
  int          cycle_count = 0;

  custom_float_scale_accumulate uut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .action         (action),
    .lane           (lane),
    .value_exponent (value_exponent),
    .value_mantissa (value_mantissa),
    .multiplier     (multiplier),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_lane       (out_lane),
    .sum_exp_out    (sum_exp_out),
    .sum_mant_out   (sum_mant_out),
    .overflow       (overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic cfloat_t trunc_add(cfloat_t a, cfloat_t b);
    int unsigned d;
    if (a.e == 0 && a.m == 0) return b;
    if (b.e == 0 && b.m == 0) return a;
    if (a.e > b.e) begin
      d = a.e - b.e;
      b.m = (d >= MANT_W) ? 0 : (b.m >> d);
    end else if (b.e > a.e) begin
      d = b.e - a.e;
      a.m = (d >= MANT_W) ? 0 : (a.m >> d);
      a.e = b.e;
    end
    a.m = a.m + b.m;
    if (a.m > int'(MANT_LIMIT)) begin
      a.e = a.e + 1;
      a.m = a.m >> 1;
    end
    return a;
  endfunction

  function automatic sum_beat_t scale_accumulate(acc_beat_t b);
    cfloat_t   prod;
    cfloat_t   term;
    cfloat_t   acc;
    sum_beat_t res;
    prod = '{0, 0};
    acc = '{0, 0};
    res.lane = b.lane;
    res.ovf = 1'b0;
    if (b.lane < NUM_LANES) begin
      if (b.action == ACT_CLEAR) begin
        lane_exp[b.lane] = 0;
        lane_mant[b.lane] = 0;
      end else begin
        if (!(b.vexp == 0 && b.vmant == 0)) begin
          for (int i = 0; i < MULT_BITS; i++) begin
            if (b.mult[i]) begin
              term.e = int'(b.vexp) + i;
              term.m = int'(b.vmant);
              prod = trunc_add(prod, term);
            end
          end
        end
        acc.e = lane_exp[b.lane];
        acc.m = lane_mant[b.lane];
        acc = trunc_add(acc, prod);
        if (acc.e > int'(EXP_MAX)) begin
          acc.e = int'(EXP_MAX);
          acc.m = int'(MANT_LIMIT);
          res.ovf = 1'b1;
        end
        lane_exp[b.lane] = acc.e;
        lane_mant[b.lane] = acc.m;
      end
    end
    res.expo = acc.e[VEXP_W-1:0];
    res.mant = acc.m[VMANT_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic queue_beat(logic act, int ln, int e, int m, int mult, bit drain = 1'b0);
    acc_beat_t b;
    b.action = act;
    b.lane = ln[LANE_W-1:0];
    b.vexp = e[VEXP_W-1:0];
    b.vmant = m[VMANT_W-1:0];
    b.mult = mult[MULT_W-1:0];
    b.drain = drain;
    beats_to_send.push_back(b);
  endtask

  always @(posedge clk) begin
    logic take;
    logic offer;
    take = item_valid && !item_stall;
    offer = item_valid && !take;
    if (!rst) begin
      if (take) begin
        sums_due.push_back(scale_accumulate(offered));
        items_in <= items_in + 1;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 7);
        end else if (beats_to_send.size() != 0 &&
                     (!beats_to_send[0].drain || items_in + int'(take) == results_out)) begin
          offered = beats_to_send.pop_front();
          action <= offered.action;
          lane <= offered.lane;
          value_exponent <= offered.vexp;
          value_mantissa <= offered.vmant;
          multiplier <= offered.mult;
          offer = 1'b1;
        end
      end
      calm <= beats_to_send.size() < QUIET_TAIL;
    end
    item_valid <= offer;
  end

  always @(posedge clk) begin
    sum_beat_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (sums_due.size() == 0) begin
          $display("%0t: result with none expected, actual lane %0d exp %0d mant %0d ovf %0d",
                   $time, out_lane, sum_exp_out, sum_mant_out, overflow);
          errors++;
        end else begin
          want = sums_due.pop_front();
          if (out_lane !== want.lane) note_mismatch("out_lane", want.lane, out_lane);
          if (sum_exp_out !== want.expo) note_mismatch("sum_exp_out", want.expo, sum_exp_out);
          if (sum_mant_out !== want.mant) note_mismatch("sum_mant_out", want.mant, sum_mant_out);
          if (overflow !== want.ovf) note_mismatch("overflow", want.ovf, overflow);
        end
        results_out <= results_out + 1;
      end
      // hold off once for long enough to back the block up
      if (hold_left != 0) begin
        hold_left--;
      end else if (!long_hold_done && results_out >= LONG_HOLD_AT) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 8);
      end
    end
    result_stall <= (hold_left != 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("custom_float_scale_accumulate_test: errors");
      $finish;
    end
  end

  initial begin
    int pick;
    int ln;
    int e;
    int m;
    int mult;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_exp[i] = 0;
      lane_mant[i] = 0;
    end

    queue_beat(ACT_CLEAR, 0, 0, 0, 0);
    queue_beat(ACT_ACC, 0, 31, 'h4000, 1);
    queue_beat(ACT_ACC, 0, 31, 'h4000, 1);
    queue_beat(ACT_ACC, 0, 0, 0, 'hFFFF);
    queue_beat(ACT_ACC, 0, 40, 'h7FFF, 0);
    queue_beat(ACT_ACC, 1, 0, 'h7FFF, 'hFFFF);
    queue_beat(ACT_ACC, 1, 5, 0, 3);
    queue_beat(ACT_ACC, 31, 63, 'h7FFF, 'hFFFF);
    queue_beat(ACT_ACC, 31, 0, 1, 1);
    queue_beat(ACT_CLEAR, 31, 63, 'h7FFF, 'hFFFF);
    queue_beat(ACT_ACC, 2, 50, 'h4000, 1);
    queue_beat(ACT_ACC, 2, 10, 'h7FFF, 'hFFFF);
    queue_beat(ACT_ACC, 3, 0, 0, 0);
    queue_beat(ACT_ACC, 3, 63, 0, 'h8000);
    queue_beat(ACT_ACC, 4, 1, 1, 'h5555);
    queue_beat(ACT_ACC, 4, 20, 'h2AAA, 'hAAAA);
    queue_beat(ACT_ACC, 5, 48, 'h7FFF, 1);
    queue_beat(ACT_ACC, 5, 48, 'h7FFF, 1);
    queue_beat(ACT_ACC, 5, 62, 'h7FFF, 2);
    queue_beat(ACT_CLEAR, 5, 0, 0, 0);
    queue_beat(ACT_CLEAR, 17, 0, 0, 0);
    queue_beat(ACT_ACC, 16, 31, 'h4000, 'hFFFF);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      ln = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, NUM_LANES - 1);
      pick = $urandom_range(0, 9);
      if (pick == 0) e = 0;
      else if (pick <= 5) e = $urandom_range(0, 30);
      else if (pick <= 8) e = $urandom_range(31, 50);
      else e = $urandom_range(0, 63);
      pick = $urandom_range(0, 19);
      if (pick < 3) m = 0;
      else if (pick < 11) m = 'h4000 | $urandom_range(0, 'h3FFF);
      else m = $urandom_range(0, 'h7FFF);
      pick = $urandom_range(0, 19);
      if (pick < 3) mult = $urandom_range(0, 15);
      else if (pick < 5) mult = 0;
      else if (pick < 7) mult = 'hFFFF;
      else if (pick < 9) mult = 1 << $urandom_range(0, MULT_W - 1);
      else mult = $urandom_range(0, 'hFFFF);
      queue_beat(($urandom_range(0, 11) == 0) ? ACT_CLEAR : ACT_ACC, ln, e, m, mult,
                 beats_to_send.size() == DRAIN_AT);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (beats_to_send.size() != 0 || item_valid || items_in != results_out)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && sums_due.size() == 0) begin
      $display("custom_float_scale_accumulate_test: clean");
    end else begin
      $display("custom_float_scale_accumulate_test: errors");
    end
    $finish;
  end

endmodule
